@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl files that check themselves
// depends on a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define MDME_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define MDME_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MDME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mdme_pkg.sv @@
// shared types and constants for the match distance spread estimator
// no dependencies
`timescale 1ns / 1ps

package mdme_pkg;

    // store geometry
    localparam int MAX_MATCHES = 64;
    localparam int CNT_W       = $clog2(MAX_MATCHES + 1);
    localparam int STEP_W      = $clog2(MAX_MATCHES);
    localparam int NUM_LANES   = 2;
    localparam int LANE_NEAR   = 0;
    localparam int LANE_GAP    = 1;

    // distance and result formats
    localparam int DIST_W   = 9;
    localparam int SPREAD_W = 25;
    localparam logic [DIST_W-1:0] DIST_MAX = 9'd256;

    // spread = mad * 97163 + floor((mad * 842 + 625) / 1250)
    localparam int FRAC_W      = 18;
    localparam int RECIP_W     = 18;
    localparam int PROD_W      = FRAC_W + RECIP_W;
    localparam int RECIP_SHIFT = 28;
    localparam logic [SPREAD_W-1:0] SCALE_INT = 25'd97163;
    localparam logic [FRAC_W-1:0]   FRAC_NUM  = 18'd842;
    localparam logic [FRAC_W-1:0]   ROUND_ADD = 18'd625;
    // ceil(2^28 / 1250), exact floor division for the 18-bit range
    localparam logic [RECIP_W-1:0]  RECIP     = 18'd214749;

    // one input beat
    typedef struct packed {
        logic [DIST_W-1:0] nearest_distance;
        logic [DIST_W-1:0] second_distance;
        logic              last_item;
    } in_t;

    // one result beat
    typedef struct packed {
        logic [SPREAD_W-1:0] nearest_spread;
        logic [SPREAD_W-1:0] gap_spread;
        logic                overflowed;
    } out_t;

    // one value per lane: nearest distance and gap
    typedef logic [NUM_LANES-1:0][DIST_W-1:0] dpair_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic load;
        logic init;
        logic rank;
        logic extract;
        logic deviate;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/mdme_cell.sv @@
// one cell of the ring: holds one stored match (nearest and gap lanes),
// ranks it against the circulating values; depends on mdme_pkg
`timescale 1ns / 1ps

module mdme_cell
    import mdme_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic             valid,
    input  logic [CNT_W-1:0] k,
    input  dpair_t           hold_in,
    input  dpair_t           circ_in,
    input  logic             cv_in,
    output dpair_t           hold,
    output dpair_t           circ,
    output logic             cv
);

    dpair_t                            hold_reg, hold_next;
    dpair_t                            circ_reg, circ_next;
    logic                              cv_reg, cv_next;
    logic [NUM_LANES-1:0][CNT_W-1:0]   lt_reg, lt_next;
    logic [NUM_LANES-1:0][CNT_W-1:0]   le_reg, le_next;
    logic [NUM_LANES-1:0]              lt_inc, le_inc, flag;
    dpair_t                            dev;

    // per-lane compare, selection flag and absolute deviation
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            lt_inc[l] = cv_reg && (circ_reg[l] < hold_reg[l]);
            le_inc[l] = cv_reg && (circ_reg[l] <= hold_reg[l]);
            flag[l]   = valid && (lt_reg[l] <= k) && (k < le_reg[l]);
            dev[l]    = (hold_reg[l] >= circ_reg[l]) ? (hold_reg[l] - circ_reg[l])
                                                     : (circ_reg[l] - hold_reg[l]);
        end
    end

    // next state of the cell
    always_comb
    begin
        hold_next = hold_reg;
        circ_next = circ_reg;
        cv_next   = cv_reg;
        lt_next   = lt_reg;
        le_next   = le_reg;
        if (ctrl.load)
        begin
            hold_next = hold_in;
        end
        if (ctrl.deviate)
        begin
            hold_next = dev;
        end
        if (ctrl.init)
        begin
            circ_next = hold_reg;
            cv_next   = valid;
            lt_next   = '0;
            le_next   = '0;
        end
        if (ctrl.rank)
        begin
            circ_next = circ_in;
            cv_next   = cv_in;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                lt_next[l] = lt_reg[l] + CNT_W'(lt_inc[l]);
                le_next[l] = le_reg[l] + CNT_W'(le_inc[l]);
            end
        end
        if (ctrl.extract)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                circ_next[l] = flag[l] ? hold_reg[l] : circ_in[l];
            end
        end
    end

    // circulating valid mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg <= 1'b0;
        end
        else
        begin
            cv_reg <= cv_next;
        end
    end

    // stored value, circulating value and rank counts
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        circ_reg <= circ_next;
        lt_reg   <= lt_next;
        le_reg   <= le_next;
    end

    assign hold = hold_reg;
    assign circ = circ_reg;
    assign cv   = cv_reg;

endmodule

@@ hw/rtl/mdme_scale.sv @@
// two-stage fixed-point scaler: spread = round(1.4826 * mad * 2^16)
// depends on mdme_pkg
`timescale 1ns / 1ps

module mdme_scale
    import mdme_pkg::*;
(
    input  logic                clk,
    input  logic [DIST_W-1:0]   mad,
    output logic [SPREAD_W-1:0] spread
);

    logic [SPREAD_W-1:0]               base_reg, base_next;
    logic [FRAC_W-1:0]                 y_reg, y_next;
    logic [SPREAD_W-1:0]               spread_reg, spread_next;
    logic [PROD_W-1:0]                 prod;
    logic [PROD_W-RECIP_SHIFT-1:0]     q;

    // stage one: integer part and rounding numerator
    always_comb
    begin
        base_next = SPREAD_W'(mad) * SCALE_INT;
        y_next    = FRAC_W'(mad) * FRAC_NUM + ROUND_ADD;
    end

    // stage two: divide the numerator by 1250 through the reciprocal
    always_comb
    begin
        prod        = PROD_W'(y_reg) * PROD_W'(RECIP);
        q           = prod[PROD_W-1:RECIP_SHIFT];
        spread_next = base_reg + SPREAD_W'(q);
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        y_reg      <= y_next;
        spread_reg <= spread_next;
    end

    assign spread = spread_reg;

endmodule

@@ hw/rtl/match_distance_mad_estimator_unit.sv @@
// top level of the match distance spread estimator: ring of storage cells,
// sequencer and scalers; depends on mdme_pkg, mdme_cell, mdme_scale, assert_macros.svh
// sequence: a non-final beat is taken while idle; after a final beat, done pulses once
// the sequencer has found two medians, each by a rank rotation and an extract rotation
// of the 64-cell ring, and has waited through the deviation step and the 2-stage scaler
// a new set is taken only after done, when the unit is idle again; the receiver cannot stall
// reset: asynchronous, clears count, overflow flag and sequencer; the store is not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module match_distance_mad_estimator_unit
    import mdme_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  item,
    output logic done,
    output out_t result
);

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INIT    = 3'd1;
    localparam logic [2:0] ST_RANK    = 3'd2;
    localparam logic [2:0] ST_EXTRACT = 3'd3;
    localparam logic [2:0] ST_DEVIATE = 3'd4;
    localparam logic [2:0] ST_SCALE   = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(MAX_MATCHES - 1);
    localparam logic [STEP_W-1:0] SCALE_LAST = STEP_W'(1);
    localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(MAX_MATCHES);

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              pass_reg, pass_next;
    logic [CNT_W-1:0]  item_count_reg, item_count_next;
    logic              overflow_reg, overflow_next;

    logic              accept;
    logic              store_ok;
    logic [DIST_W-1:0] nd_sat, sd_sat;
    dpair_t            new_pair;
    cell_ctrl_t        ctrl;
    logic [CNT_W-1:0]  k;

    dpair_t            hold_w [MAX_MATCHES];
    dpair_t            circ_w [MAX_MATCHES];
    logic              cv_w   [MAX_MATCHES];

    logic [SPREAD_W-1:0] near_spread, gap_spread_w;

    // input beat: saturate distances and form the gap
    always_comb
    begin
        nd_sat = (item.nearest_distance > DIST_MAX) ? DIST_MAX : item.nearest_distance;
        sd_sat = (item.second_distance > DIST_MAX) ? DIST_MAX : item.second_distance;
        new_pair[LANE_NEAR] = nd_sat;
        new_pair[LANE_GAP]  = (sd_sat > nd_sat) ? (sd_sat - nd_sat) : '0;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign store_ok = (item_count_reg < CNT_FULL);
    assign k        = item_count_reg >> 1;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        pass_next       = pass_reg;
        item_count_next = item_count_reg;
        overflow_next   = overflow_reg;
        ctrl            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (store_ok)
                    begin
                        ctrl.load       = 1'b1;
                        item_count_next = item_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (item.last_item)
                    begin
                        state_next = ST_INIT;
                        pass_next  = 1'b0;
                    end
                end
            end
            ST_INIT:
            begin
                ctrl.init  = 1'b1;
                step_next  = '0;
                state_next = ST_RANK;
            end
            ST_RANK:
            begin
                ctrl.rank = 1'b1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_EXTRACT;
                end
            end
            ST_EXTRACT:
            begin
                ctrl.extract = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    step_next  = '0;
                    state_next = pass_reg ? ST_SCALE : ST_DEVIATE;
                end
            end
            ST_DEVIATE:
            begin
                ctrl.deviate = 1'b1;
                pass_next    = 1'b1;
                state_next   = ST_INIT;
            end
            ST_SCALE:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == SCALE_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                item_count_next = '0;
                overflow_next   = 1'b0;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            pass_reg       <= 1'b0;
            item_count_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            pass_reg       <= pass_next;
            item_count_reg <= item_count_next;
            overflow_reg   <= overflow_next;
        end
    end

    // ring of cells: loads shift in at cell 0, rotations close through the last cell
    for (genvar i = 0; i < MAX_MATCHES; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? (MAX_MATCHES - 1) : (i - 1);
        dpair_t hold_in;
        logic   valid;

        if (i == 0)
        begin : g_head
            assign hold_in = new_pair;
        end
        else
        begin : g_body
            assign hold_in = hold_w[PREV];
        end

        assign valid = (CNT_W'(i) < item_count_reg);

        mdme_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .valid   (valid),
            .k       (k),
            .hold_in (hold_in),
            .circ_in (circ_w[PREV]),
            .cv_in   (cv_w[PREV]),
            .hold    (hold_w[i]),
            .circ    (circ_w[i]),
            .cv      (cv_w[i])
        );
    end

    // after the second extract every cell carries the mad of its lane
    mdme_scale u_scale_near (
        .clk    (clk),
        .mad    (circ_w[MAX_MATCHES-1][LANE_NEAR]),
        .spread (near_spread)
    );

    mdme_scale u_scale_gap (
        .clk    (clk),
        .mad    (circ_w[MAX_MATCHES-1][LANE_GAP]),
        .spread (gap_spread_w)
    );

    // result beat
    assign done                  = (state_reg == ST_DONE);
    assign result.nearest_spread = near_spread;
    assign result.gap_spread     = gap_spread_w;
    assign result.overflowed     = overflow_reg;

    // checks
    `MDME_ASSERT(a_count_bound, item_count_reg <= CNT_FULL, "item count above capacity")
    `MDME_ASSERT_IMPL(a_done_nonempty, done, item_count_reg != '0, "result on an empty set")
    `MDME_ASSERT_NEXT(a_done_single, done, !done && item_count_reg == '0 && !overflow_reg,
        "result not single or set not cleared")
    `MDME_ASSERT_NEXT(a_full_drop, start && !busy && item_count_reg == CNT_FULL,
        overflow_reg && item_count_reg == CNT_FULL, "dropped beat not flagged")

endmodule
